[rtl/dabr_pkg.sv]
// ----------------------------------------------------------------------------
// dabr_pkg
// Types, angle constants and the arctangent table for the ray angle pipeline
// ----------------------------------------------------------------------------
package dabr_pkg;

	// cordic datapath width, vectors are normalized to [2^40, 2^41)
	localparam int CW = 44;
	localparam int MW = 41;
	// signed angle accumulator, units of 1/64 degree * 2^-16
	localparam int ZW = 32;
	// unsigned wrapped direction
	localparam int DW = 31;
	localparam int FINE_SHIFT = 16;
	localparam int ANGLE_W = 15;
	localparam int ATAN_ENTRIES = 24;

	localparam logic [DW-1:0] FULL_TURN = 31'd1509949440;
	localparam logic [DW-1:0] DEG_90    = 31'd377487360;
	localparam logic [DW-1:0] DEG_180   = 31'd754974720;
	localparam logic [DW-1:0] DEG_270   = 31'd1132462080;
	localparam logic [ANGLE_W-1:0] TURN_UNITS = 15'd23040;

	typedef enum logic [1:0] {
		AX_POS_X,
		AX_POS_Y,
		AX_NEG_X,
		AX_NEG_Y
	} axis_dir_t;

	typedef struct packed {
		logic      on_axis;
		axis_dir_t dir;
	} ray_ctl_t;

	function automatic logic [ZW-1:0] atan_fine(input logic [4:0] idx);
		logic [ZW-1:0] v;
		case (idx)
			5'd0:  v = 32'd188743680;
			5'd1:  v = 32'd111421900;
			5'd2:  v = 32'd58872272;
			5'd3:  v = 32'd29884485;
			5'd4:  v = 32'd15000234;
			5'd5:  v = 32'd7507429;
			5'd6:  v = 32'd3754631;
			5'd7:  v = 32'd1877430;
			5'd8:  v = 32'd938729;
			5'd9:  v = 32'd469366;
			5'd10: v = 32'd234683;
			5'd11: v = 32'd117342;
			5'd12: v = 32'd58671;
			5'd13: v = 32'd29335;
			5'd14: v = 32'd14668;
			5'd15: v = 32'd7334;
			5'd16: v = 32'd3667;
			5'd17: v = 32'd1833;
			5'd18: v = 32'd917;
			5'd19: v = 32'd458;
			5'd20: v = 32'd229;
			5'd21: v = 32'd115;
			5'd22: v = 32'd57;
			5'd23: v = 32'd29;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [DW-1:0] axis_angle(input axis_dir_t d);
		logic [DW-1:0] v;
		case (d)
			AX_POS_X: v = '0;
			AX_POS_Y: v = DEG_90;
			AX_NEG_X: v = DEG_180;
			AX_NEG_Y: v = DEG_270;
			default:  v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/directed_angle_between_rays.sv]
// ----------------------------------------------------------------------------
// directed_angle_between_rays
// Directed angle from ray AB to ray AC, counter-clockwise, 1/64 degree units
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one query per transaction: vertex A and the
//   points B and C as signed COORD_BITS-bit coordinates. Output stream m_axis
//   returns one result per query, in order: the angle in tdata and the
//   degenerate flag (B or C equal to A, angle then 0) in tuser.
//   The stages are: one for the ray differences, one for the half-plane
//   fold, two for normalization, one per cordic iteration for both rays side
//   by side, then direction wrap, difference and rounding. A new query is
//   taken every cycle unless s_axis_tready is low.
//   Each stage holds its own valid bit and moves on as soon as the stage
//   after it is empty or moving, so bubbles close up while the receiver
//   stalls; s_axis_tready falls only when every stage holds a query and
//   m_axis_tready is low. Nothing is lost or repeated across a stall.
//   Reset clears all valid bits; no query is in flight after reset.
// ----------------------------------------------------------------------------
module directed_angle_between_rays import dabr_pkg::*; #(
	parameter int COORD_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// vertex_x, vertex_y, first_x, first_y, second_x, second_y, zero fill
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// angle, zero fill
	output logic [15:0]                               m_axis_tdata,
	// degenerate
	output logic [0:0]                                m_axis_tuser
);

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int FOLD_W  = COORD_BITS + 2;
	localparam int ST_C0   = 5;
	localparam int ST_DIR  = CORDIC_STAGES + 5;
	localparam int ST_SUB  = CORDIC_STAGES + 6;
	localparam int ST_OUT  = CORDIC_STAGES + 7;
	localparam int NS      = ST_OUT;

	logic [NS:1]   vld_q;
	logic [NS+1:1] ld;
	logic [NS-1:0] vld_in;

	always_comb begin
		ld[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign vld_in = {vld_q[NS-1:1], s_axis_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_in[k-1];
				end
			end
		end
	end

	assign s_axis_tready = ld[1];

	// stage 1: ray differences
	logic signed [COORD_BITS-1:0] crd [6];
	logic signed [DIFF_W-1:0]     dx_s1 [2];
	logic signed [DIFF_W-1:0]     dy_s1 [2];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			crd[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int l = 0; l < 2; l++) begin
				dx_s1[l] <= DIFF_W'(crd[2+2*l]) - DIFF_W'(crd[0]);
				dy_s1[l] <= DIFF_W'(crd[3+2*l]) - DIFF_W'(crd[1]);
			end
		end
	end

	// stage 2: axis check, fold into right half-plane
	logic signed [CW-1:0] x_s2 [2];
	logic signed [CW-1:0] y_s2 [2];
	logic [MW-1:0]        m_s2 [2];
	logic signed [ZW-1:0] z_s2 [2];
	ray_ctl_t             ctl_s2 [2];
	logic                 dg_s2;

	logic signed [FOLD_W-1:0] fx [2];
	logic signed [FOLD_W-1:0] fy [2];
	logic signed [FOLD_W-1:0] fm [2];
	logic [DW-1:0]            fz [2];
	ray_ctl_t                 fctl [2];
	logic                     fdg;

	always_comb begin
		logic signed [FOLD_W-1:0] ay;
		logic x0, y0, xneg, yneg;
		fdg = 1'b0;
		for (int l = 0; l < 2; l++) begin
			x0   = (dx_s1[l] == '0);
			y0   = (dy_s1[l] == '0);
			xneg = dx_s1[l][DIFF_W-1];
			yneg = dy_s1[l][DIFF_W-1];
			fdg  = fdg || (x0 && y0);
			fctl[l].on_axis = x0 || y0;
			if (y0) begin
				fctl[l].dir = (!xneg && !x0) ? AX_POS_X : AX_NEG_X;
			end else begin
				fctl[l].dir = !yneg ? AX_POS_Y : AX_NEG_Y;
			end
			fx[l] = xneg ? -FOLD_W'(dx_s1[l]) : FOLD_W'(dx_s1[l]);
			fy[l] = xneg ? -FOLD_W'(dy_s1[l]) : FOLD_W'(dy_s1[l]);
			fz[l] = xneg ? DEG_180 : '0;
			ay    = fy[l][FOLD_W-1] ? -fy[l] : fy[l];
			fm[l] = (fx[l] > ay) ? fx[l] : ay;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int l = 0; l < 2; l++) begin
				x_s2[l]   <= CW'(fx[l]);
				y_s2[l]   <= CW'(fy[l]);
				m_s2[l]   <= MW'($unsigned(fm[l]));
				z_s2[l]   <= ZW'(fz[l]);
				ctl_s2[l] <= fctl[l];
			end
			dg_s2 <= fdg;
		end
	end

	// stages 3 and 4: normalize so the larger component reaches 2^40
	logic signed [CW-1:0] x_s3 [2];
	logic signed [CW-1:0] y_s3 [2];
	logic [MW-1:0]        m_s3 [2];
	logic signed [ZW-1:0] z_s3 [2];
	ray_ctl_t             ctl_s3 [2];
	logic                 dg_s3;
	logic signed [CW-1:0] x_s4 [2];
	logic signed [CW-1:0] y_s4 [2];
	logic signed [ZW-1:0] z_s4 [2];
	ray_ctl_t             ctl_s4 [2];
	logic                 dg_s4;

	logic signed [CW-1:0] na_x [2];
	logic signed [CW-1:0] na_y [2];
	logic [MW-1:0]        na_m [2];
	logic signed [CW-1:0] nb_x [2];
	logic signed [CW-1:0] nb_y [2];

	always_comb begin
		logic [MW-1:0] m;
		for (int l = 0; l < 2; l++) begin
			m       = m_s2[l];
			na_x[l] = x_s2[l];
			na_y[l] = y_s2[l];
			for (int j = 0; j < 3; j++) begin
				if ((m >> (MW - (32 >> j))) == '0) begin
					m       = m << (32 >> j);
					na_x[l] = na_x[l] <<< (32 >> j);
					na_y[l] = na_y[l] <<< (32 >> j);
				end
			end
			na_m[l] = m;
		end
	end

	always_comb begin
		logic [MW-1:0] m;
		for (int l = 0; l < 2; l++) begin
			m       = m_s3[l];
			nb_x[l] = x_s3[l];
			nb_y[l] = y_s3[l];
			for (int j = 0; j < 3; j++) begin
				if ((m >> (MW - (4 >> j))) == '0) begin
					m       = m << (4 >> j);
					nb_x[l] = nb_x[l] <<< (4 >> j);
					nb_y[l] = nb_y[l] <<< (4 >> j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			x_s3   <= na_x;
			y_s3   <= na_y;
			m_s3   <= na_m;
			z_s3   <= z_s2;
			ctl_s3 <= ctl_s2;
			dg_s3  <= dg_s2;
		end
		if (ld[4]) begin
			x_s4   <= nb_x;
			y_s4   <= nb_y;
			z_s4   <= z_s3;
			ctl_s4 <= ctl_s3;
			dg_s4  <= dg_s3;
		end
	end

	// stages 5 onward: one cordic iteration per stage, both rays in parallel
	logic signed [CW-1:0] cx_s5  [CORDIC_STAGES][2];
	logic signed [CW-1:0] cy_s5  [CORDIC_STAGES][2];
	logic signed [ZW-1:0] cz_s5  [CORDIC_STAGES][2];
	ray_ctl_t             cct_s5 [CORDIC_STAGES][2];
	logic                 cdg_s5 [CORDIC_STAGES];

	logic signed [CW-1:0] cx_in  [CORDIC_STAGES][2];
	logic signed [CW-1:0] cy_in  [CORDIC_STAGES][2];
	logic signed [ZW-1:0] cz_in  [CORDIC_STAGES][2];
	ray_ctl_t             cct_in [CORDIC_STAGES][2];
	logic                 cdg_in [CORDIC_STAGES];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
		if (k == 0) begin : g_first
			assign cx_in[k]  = x_s4;
			assign cy_in[k]  = y_s4;
			assign cz_in[k]  = z_s4;
			assign cct_in[k] = ctl_s4;
			assign cdg_in[k] = dg_s4;
		end else begin : g_next
			assign cx_in[k]  = cx_s5[k-1];
			assign cy_in[k]  = cy_s5[k-1];
			assign cz_in[k]  = cz_s5[k-1];
			assign cct_in[k] = cct_s5[k-1];
			assign cdg_in[k] = cdg_s5[k-1];
		end

		always_ff @(posedge clk) begin
			if (ld[ST_C0+k]) begin
				cdg_s5[k] <= cdg_in[k];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic signed [CW-1:0] xs;
			logic signed [CW-1:0] ys;
			logic                 pos;
			logic [ZW-1:0]        at;

			assign xs  = cx_in[k][l] >>> k;
			assign ys  = cy_in[k][l] >>> k;
			assign pos = !cy_in[k][l][CW-1] && (|cy_in[k][l]);
			assign at  = atan_fine(5'(k));

			always_ff @(posedge clk) begin
				if (ld[ST_C0+k]) begin
					cx_s5[k][l]  <= pos ? cx_in[k][l] + ys : cx_in[k][l] - ys;
					cy_s5[k][l]  <= pos ? cy_in[k][l] - xs : cy_in[k][l] + xs;
					cz_s5[k][l]  <= pos ? cz_in[k][l] + $signed(at)
					                    : cz_in[k][l] - $signed(at);
					cct_s5[k][l] <= cct_in[k][l];
				end
			end
		end
	end

	// last three stages, numbered for the default of 16 cordic stages
	logic [DW-1:0]      dir_s21 [2];
	logic               dg_s21;
	logic [DW-1:0]      d_s22;
	logic               dg_s22;
	logic [ANGLE_W-1:0] angle_s23;
	logic               dg_s23;

	logic [DW-1:0]        wdir [2];
	logic signed [DW:0]   dfull;
	logic [DW-1:0]        dwrap;
	logic [DW:0]          rsum;
	logic [DW-FINE_SHIFT:0] rnd;

	always_comb begin
		logic signed [ZW-1:0] zl;
		for (int l = 0; l < 2; l++) begin
			zl = cz_s5[CORDIC_STAGES-1][l];
			if (cct_s5[CORDIC_STAGES-1][l].on_axis) begin
				wdir[l] = axis_angle(cct_s5[CORDIC_STAGES-1][l].dir);
			end else if (zl[ZW-1]) begin
				wdir[l] = DW'(zl + $signed(ZW'(FULL_TURN)));
			end else begin
				wdir[l] = DW'(zl);
			end
		end
	end

	assign dfull = $signed({1'b0, dir_s21[1]}) - $signed({1'b0, dir_s21[0]});
	assign dwrap = dfull[DW] ? DW'(dfull + $signed({1'b0, FULL_TURN})) : DW'(dfull);
	assign rsum  = {1'b0, d_s22} + (DW+1)'(1 << (FINE_SHIFT - 1));
	assign rnd   = rsum[DW:FINE_SHIFT];

	always_ff @(posedge clk) begin
		if (ld[ST_DIR]) begin
			dir_s21 <= wdir;
			dg_s21  <= cdg_s5[CORDIC_STAGES-1];
		end
		if (ld[ST_SUB]) begin
			d_s22  <= dwrap;
			dg_s22 <= dg_s21;
		end
		if (ld[ST_OUT]) begin
			if (dg_s22 || rnd >= (DW-FINE_SHIFT+1)'(TURN_UNITS)) begin
				angle_s23 <= '0;
			end else begin
				angle_s23 <= ANGLE_W'(rnd);
			end
			dg_s23 <= dg_s22;
		end
	end

	assign m_axis_tvalid = vld_q[NS];
	assign m_axis_tdata  = {1'b0, angle_s23};
	assign m_axis_tuser  = dg_s23;

	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_q[1])
		else $error("accepted transaction did not enter the first stage");

	a_angle_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:0] < TURN_UNITS)
		else $error("angle out of range");

	a_degenerate_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[14:0] == '0)
		else $error("degenerate result with nonzero angle");

	a_full_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline full and output stalled");

	a_bubble_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> s_axis_tready)
		else $error("first stage empty but input not ready");

endmodule
